FILE: src/first_fit_block_allocator_defines.svh
// ----------------------------------------------------------------------------
// First-fit block allocator: assertion macros
// Clocked on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared widths, defaults and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int NUM_BLOCKS_DEF = 32768;
    localparam int WORD_BITS_DEF  = 64;

    localparam int ID_W      = 15;
    localparam int STATUS_W  = 2;
    localparam int ID_LIMIT  = 32768;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

endpackage

FILE: src/ffba_if.sv
// ----------------------------------------------------------------------------
// ffba channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ffba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [ffba_pkg::ID_W-1:0] block_id;

    modport source (output valid, kind, block_id, input ready);
    modport sink   (input valid, kind, block_id, output ready);
endinterface

interface ffba_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffba_pkg::ID_W-1:0]     granted_block;
    logic [ffba_pkg::STATUS_W-1:0] status;

    modport source (output valid, granted_block, status, input ready);
    modport sink   (input valid, granted_block, status, output ready);
endinterface

interface ffba_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [ffba_pkg::ID_W-1:0] start_block;

    modport source (output valid, start_block, input ready);
    modport sink   (input valid, start_block, output ready);
endinterface

FILE: src/first_fit_block_allocator.sv
// Free: an accepted item passes the base, scan and done states on its way to the
// output register (an item out of range goes straight to done); otherwise allocate
// reads N bitmap words (1 up to MAP_WORDS, 512 by default), one word per cycle
// through the single-port read of the bitmap. One item is in work at a time; the
// next item is taken once the result sits in the output register. Reset: a
// clearing pass writes every bitmap word to zero, during which no request is taken.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Bitmap block allocator: first-fit allocate from a configured start block,
// and free of single blocks, on a word-wide read-modify-write bitmap memory.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
    parameter int NUM_BLOCKS = ffba_pkg::NUM_BLOCKS_DEF,
    parameter int WORD_BITS  = ffba_pkg::WORD_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ffba_cfg_if.sink      cfg,
    ffba_req_if.sink      req,
    ffba_rsp_if.source    rsp
);

    localparam int ID_W      = ffba_pkg::ID_W;
    localparam int STATUS_W  = ffba_pkg::STATUS_W;
    localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int OW        = $clog2(WORD_BITS);
    localparam int BW        = ID_W + 2;
    localparam int LIM       = (NUM_BLOCKS < ffba_pkg::ID_LIMIT) ? NUM_BLOCKS
                                                                : ffba_pkg::ID_LIMIT;
    // Reciprocal of WORD_BITS for block -> word index: q = (x * RECIP) >> SH
    localparam int SH        = ID_W + OW;
    localparam int RW        = ID_W + 1;
    localparam int RECIP     = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [RW-1:0] RECIP_C      = RW'(RECIP);
    localparam logic [31:0]   NUM_BLOCKS_C = 32'(NUM_BLOCKS);
    localparam logic [BW-1:0] LIM_C        = BW'(LIM);
    localparam logic [BW-1:0] WORD_BITS_C  = BW'(WORD_BITS);
    localparam logic [AW-1:0] LAST_WORD    = AW'(MAP_WORDS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_BASE  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_addr_reg, clr_addr_next;
    logic [ID_W-1:0]     fdb_reg, fdb_next;
    logic                kind_reg, kind_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [AW-1:0]       q_reg, q_next;
    logic [BW-1:0]       base_reg, base_next;
    logic [ID_W-1:0]     res_granted_reg, res_granted_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic                out_valid_reg, out_valid_next;
    logic [ID_W-1:0]     out_granted_reg, out_granted_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;

    logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    logic [ID_W-1:0]      target;
    logic [ID_W+RW-1:0]   prod;
    logic [BW-1:0]        fdb_ext;
    logic [BW-1:0]        id_ext;
    logic [BW-1:0]        off_lo;
    logic [BW-1:0]        off_hi;
    logic [BW-1:0]        id_off;
    logic [WORD_BITS-1:0] free_vec;
    logic                 hit;
    logic [OW-1:0]        hit_idx;
    logic [WORD_BITS-1:0] hit_mask;
    logic [WORD_BITS-1:0] id_mask;
    logic                 id_used;
    logic                 last_word;
    logic                 out_take;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);

    assign rsp.valid         = out_valid_reg;
    assign rsp.granted_block = out_granted_reg;
    assign rsp.status        = out_status_reg;

    assign out_take = out_valid_reg && rsp.ready;

    // Word index of the start block or the block to free
    assign target = (req.kind == ffba_pkg::KIND_FREE) ? req.block_id : fdb_reg;
    assign prod   = (ID_W+RW)'(target) * (ID_W+RW)'(RECIP_C);

    assign fdb_ext   = BW'(fdb_reg);
    assign id_ext    = BW'(id_reg);
    assign off_lo    = (fdb_ext > base_reg) ? (fdb_ext - base_reg) : '0;
    assign off_hi    = LIM_C - base_reg;
    assign id_off    = id_ext - base_reg;
    assign last_word = (base_reg + WORD_BITS_C) >= LIM_C;

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            free_vec[i] = !rd_data_reg[i] && (BW'(i) >= off_lo) && (BW'(i) < off_hi);
        end
    end

    // Lowest free bit of the current word
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                hit     = 1'b1;
                hit_idx = OW'(i);
            end
        end
    end

    assign hit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << hit_idx;
    assign id_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << id_off[OW-1:0];
    assign id_used  = rd_data_reg[id_off[OW-1:0]];

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        fdb_next         = fdb_reg;
        kind_next        = kind_reg;
        id_next          = id_reg;
        q_next           = q_reg;
        base_next        = base_reg;
        res_granted_next = res_granted_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        rd_en            = 1'b0;
        rd_addr          = q_reg;
        wr_en            = 1'b0;
        wr_addr          = q_reg;
        wr_data          = rd_data_reg;

        if (cfg.valid)
        begin
            fdb_next = cfg.start_block;
        end

        case (state_reg)
            S_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_WORD)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next        = req.kind;
                    id_next          = req.block_id;
                    q_next           = AW'(prod >> SH);
                    res_granted_next = '0;
                    state_next       = S_BASE;
                    // Out-of-range cases answer without touching the bitmap
                    if (req.kind == ffba_pkg::KIND_ALLOC && BW'(fdb_reg) >= LIM_C)
                    begin
                        res_status_next = ffba_pkg::STATUS_FULL;
                        state_next      = S_DONE;
                    end
                    else if (req.kind == ffba_pkg::KIND_FREE
                             && 32'(req.block_id) >= NUM_BLOCKS_C)
                    begin
                        res_status_next = ffba_pkg::STATUS_IGNORED;
                        state_next      = S_DONE;
                    end
                end
            end
            S_BASE:
            begin
                base_next  = BW'(q_reg) * WORD_BITS_C;
                rd_en      = 1'b1;
                rd_addr    = q_reg;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (kind_reg == ffba_pkg::KIND_FREE)
                begin
                    if (id_used)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = rd_data_reg & ~id_mask;
                        res_status_next = ffba_pkg::STATUS_DONE;
                    end
                    else
                    begin
                        res_status_next = ffba_pkg::STATUS_IGNORED;
                    end
                    state_next = S_DONE;
                end
                else if (hit)
                begin
                    wr_en            = 1'b1;
                    wr_data          = rd_data_reg | hit_mask;
                    res_granted_next = ID_W'(base_reg + BW'(hit_idx));
                    res_status_next  = ffba_pkg::STATUS_DONE;
                    state_next       = S_DONE;
                end
                else if (last_word)
                begin
                    res_status_next = ffba_pkg::STATUS_FULL;
                    state_next      = S_DONE;
                end
                else
                begin
                    // Advance to the next word, read it for the next cycle
                    q_next    = q_reg + 1'b1;
                    base_next = base_reg + WORD_BITS_C;
                    rd_en     = 1'b1;
                    rd_addr   = q_reg + 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_take)
                begin
                    out_valid_next   = 1'b1;
                    out_granted_next = res_granted_reg;
                    out_status_next  = res_status_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            map_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_addr_reg  <= '0;
            fdb_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            fdb_reg       <= fdb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        id_reg          <= id_next;
        q_reg           <= q_next;
        base_reg        <= base_next;
        res_granted_reg <= res_granted_next;
        res_status_reg  <= res_status_next;
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
    end

endmodule

FILE: src/ffba_checker.sv
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the first-fit block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module ffba_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [ffba_pkg::ID_W-1:0]     granted_block,
    input logic [ffba_pkg::STATUS_W-1:0] status
);

    logic                                         stalled;
    logic                                         req_take;
    logic                                         status_known;
    logic                                         refused;
    logic [ffba_pkg::ID_W+ffba_pkg::STATUS_W-1:0] rsp_payload;

    assign stalled      = rsp_valid && !rsp_ready;
    assign req_take     = req_valid && req_ready;
    assign status_known = (status == ffba_pkg::STATUS_DONE)
                       || (status == ffba_pkg::STATUS_FULL)
                       || (status == ffba_pkg::STATUS_IGNORED);
    assign refused      = rsp_valid && (status != ffba_pkg::STATUS_DONE);
    assign rsp_payload  = {granted_block, status};

    `FFBA_ASSERT_NEXT(a_rsp_hold, stalled, rsp_valid, "response dropped while stalled")
    `FFBA_ASSERT_NEXT(a_rsp_data, stalled, $stable(rsp_payload), "payload changed in stall")
    `FFBA_ASSERT_NOW(a_status_code, rsp_valid, status_known, "undefined status code")
    `FFBA_ASSERT_NOW(a_fail_zero, refused, granted_block == '0, "nonzero block on failure")
    `FFBA_ASSERT_NEXT(a_one_in_work, req_take, !req_ready, "item taken while busy")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .granted_block (rsp.granted_block),
    .status        (rsp.status)
);
